>>> rtl/ipds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipds_pkg
// Types and constants shared by the image pair difference statistics block.
// ----------------------------------------------------------------------------
package ipds_pkg;

  localparam int unsigned MAX_PIXELS         = 4194304;
  localparam int unsigned CHANNELS_PER_PIXEL = 4;
  localparam int unsigned SAMPLE_W           = 32;
  localparam int unsigned SUM_W              = 56;
  localparam int unsigned CNT_W              = 24;
  localparam int unsigned SQ_W               = 64;
  localparam int unsigned TOL_W              = 16;
  localparam int unsigned POS_W              = $clog2(CHANNELS_PER_PIXEL);

  localparam logic [POS_W-1:0] ALPHA_POS = POS_W'(CHANNELS_PER_PIXEL - 1);

  localparam longint unsigned CNT_CAP_RAW = 3 * longint'(MAX_PIXELS);
  localparam logic [CNT_W-1:0] CNT_MAX =
    (CNT_CAP_RAW > ((longint'(1) << CNT_W) - 1)) ? {CNT_W{1'b1}} : CNT_W'(CNT_CAP_RAW);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef logic [TOL_W-1:0] tol_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_first;
    logic [SAMPLE_W-1:0] sample_second;
    logic                image_end;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] abs_difference;
    logic                report_valid;
    logic                images_differ;
    logic [CNT_W-1:0]    large_error_count;
    logic [CNT_W-1:0]    small_error_count;
    logic [SUM_W-1:0]    total_first;
    logic [SUM_W-1:0]    total_second;
    logic [SQ_W-1:0]     squared_error_total;
  } out_item_t;

endpackage

>>> rtl/ipds_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipds_if
// Valid/ready channels for sample pair requests and results.
// ----------------------------------------------------------------------------
interface ipds_in_if;
  import ipds_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ipds_out_if;
  import ipds_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/image_pair_difference_stats_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_pair_difference_stats_top
// Per-sample absolute difference of two RGBA images with running sums,
// relative error counts, saturating squared error and an end-of-image verdict.
//
//   channel   direction  handshake      payload
//   in_ch     input      valid/ready    sample_first, sample_second, image_end
//   out_ch    output     valid/ready    abs_difference + image statistics
//   cfg_      input      cfg_wr_en      cfg_wr_data = tolerance_percent (8.8)
//
// Six register stages: input, difference/square, accumulate, gap/min,
// partial products, verdict/output. One request per cycle while the output does not stall.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up while the output stalls. Reset (synchronous, rst_n low)
// clears the pipe, the channel counter, the accumulators and the tolerance.
// ----------------------------------------------------------------------------
module image_pair_difference_stats_top (
  input  logic              clk,
  input  logic              rst_n,
  ipds_in_if.sink           in_ch,
  ipds_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  ipds_pkg::tol_t    cfg_wr_data
);
  import ipds_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
    logic [CNT_W-1:0] small_cnt;
    logic [CNT_W-1:0] large_cnt;
    logic [SQ_W-1:0]  sq;
  } stats_t;

  tol_t tol_r;

  // stage valids and advance enables
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || out_ch.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  assign in_ch.ready = rdy0;

  // stage 0: input register
  logic [POS_W-1:0]    pos_r;
  logic [SAMPLE_W-1:0] a0_r, b0_r;
  logic                last0_r, alpha0_r;

  // stage 1: difference, error tests, square
  logic [SAMPLE_W-1:0] a1_r, b1_r, d1_r;
  logic                last1_r, use1_r, small1_r, large1_r;
  logic [SQ_W-1:0]     sq1_r;

  logic [SAMPLE_W-1:0] diff;
  logic [39:0]         d_ext, d200, d20, a_ext;
  logic [SQ_W-1:0]     d_sq;

  assign diff  = (a0_r > b0_r) ? (a0_r - b0_r) : (b0_r - a0_r);
  assign d_ext = {8'd0, diff};
  assign a_ext = {8'd0, a0_r};
  assign d200  = (d_ext << 7) + (d_ext << 6) + (d_ext << 3);
  assign d20   = (d_ext << 4) + (d_ext << 2);
  assign d_sq  = {32'd0, diff} * {32'd0, diff};

  // stage 2: accumulate
  stats_t              acc_r, acc_upd;
  stats_t              st2_r;
  logic [SAMPLE_W-1:0] d2_r;
  logic                last2_r;

  logic [SUM_W:0]      sum_a_ext, sum_b_ext;
  logic [SQ_W:0]       sq_ext;

  assign sum_a_ext = {1'b0, acc_r.sum_a} + {25'd0, a1_r};
  assign sum_b_ext = {1'b0, acc_r.sum_b} + {25'd0, b1_r};
  assign sq_ext    = {1'b0, acc_r.sq} + {17'd0, sq1_r[SQ_W-1:16]};

  always_comb begin
    acc_upd = acc_r;
    if (use1_r) begin
      acc_upd.sum_a = sum_a_ext[SUM_W] ? SUM_MAX : sum_a_ext[SUM_W-1:0];
      acc_upd.sum_b = sum_b_ext[SUM_W] ? SUM_MAX : sum_b_ext[SUM_W-1:0];
      acc_upd.sq    = sq_ext[SQ_W] ? {SQ_W{1'b1}} : sq_ext[SQ_W-1:0];
      if (small1_r && (acc_r.small_cnt != CNT_MAX)) begin
        acc_upd.small_cnt = acc_r.small_cnt + CNT_W'(1);
      end
      if (large1_r && (acc_r.large_cnt != CNT_MAX)) begin
        acc_upd.large_cnt = acc_r.large_cnt + CNT_W'(1);
      end
    end
  end

  // stage 3: sum gap and smaller sum
  stats_t              st3_r;
  logic [SUM_W-1:0]    gap3_r, min3_r;
  logic [SAMPLE_W-1:0] d3_r;
  logic                last3_r;

  // stage 4: products for the tolerance test
  stats_t              st4_r;
  logic [43:0]         plo4_r, phi4_r;
  logic [70:0]         gscl4_r;
  logic                strict4_r;
  logic [SAMPLE_W-1:0] d4_r;
  logic                last4_r;

  logic [70:0]         gap_ext;
  assign gap_ext = {15'd0, gap3_r};

  // stage 5: verdict into the output register
  out_item_t           out_r, out_nxt;
  logic [71:0]         rhs;
  logic                differ;

  assign rhs    = {phi4_r, 28'd0} + {28'd0, plo4_r};
  assign differ = (tol_r == '0) ? strict4_r : ({1'b0, gscl4_r} > rhs);

  always_comb begin
    out_nxt                = '0;
    out_nxt.abs_difference = d4_r;
    if (last4_r) begin
      out_nxt.report_valid        = 1'b1;
      out_nxt.images_differ       = differ;
      out_nxt.large_error_count   = st4_r.large_cnt;
      out_nxt.small_error_count   = st4_r.small_cnt;
      out_nxt.total_first         = st4_r.sum_a;
      out_nxt.total_second        = st4_r.sum_b;
      out_nxt.squared_error_total = st4_r.sq;
    end
  end

  assign out_ch.valid = v5_r;
  assign out_ch.data  = out_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
      pos_r <= '0;
      acc_r <= '0;
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
      if (in_ch.valid && rdy0) begin
        pos_r <= in_ch.data.image_end ? '0 : pos_r + POS_W'(1);
      end
      // clear the accumulators after the last sample of an image
      if (rdy2 && v1_r) begin
        acc_r <= last1_r ? '0 : acc_upd;
      end
      if (rdy0) v0_r <= in_ch.valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (rdy0) begin
      a0_r     <= in_ch.data.sample_first;
      b0_r     <= in_ch.data.sample_second;
      last0_r  <= in_ch.data.image_end;
      alpha0_r <= (pos_r == ALPHA_POS);
    end
    if (rdy1) begin
      a1_r     <= a0_r;
      b1_r     <= b0_r;
      d1_r     <= diff;
      last1_r  <= last0_r;
      use1_r   <= !alpha0_r && !((a0_r == '0) && (b0_r == '0));
      small1_r <= d200 > a_ext;
      large1_r <= d20 > a_ext;
      sq1_r    <= d_sq;
    end
    if (rdy2) begin
      st2_r   <= acc_upd;
      d2_r    <= d1_r;
      last2_r <= last1_r;
    end
    if (rdy3) begin
      st3_r   <= st2_r;
      d3_r    <= d2_r;
      last3_r <= last2_r;
      gap3_r  <= (st2_r.sum_a > st2_r.sum_b) ? (st2_r.sum_a - st2_r.sum_b)
                                             : (st2_r.sum_b - st2_r.sum_a);
      min3_r  <= (st2_r.sum_a < st2_r.sum_b) ? st2_r.sum_a : st2_r.sum_b;
    end
    if (rdy4) begin
      st4_r     <= st3_r;
      d4_r      <= d3_r;
      last4_r   <= last3_r;
      // gap * 25600 as shifts
      gscl4_r   <= (gap_ext << 14) + (gap_ext << 13) + (gap_ext << 10);
      plo4_r    <= {16'd0, min3_r[27:0]} * {28'd0, tol_r};
      phi4_r    <= {16'd0, min3_r[55:28]} * {28'd0, tol_r};
      strict4_r <= (st3_r.small_cnt != '0) || (st3_r.large_cnt != '0);
    end
    if (rdy5) begin
      out_r <= out_nxt;
    end
  end

endmodule
